// ===== sv/b64e_pkg.sv =====
`timescale 1ns / 1ps

package b64e_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;
    localparam int unsigned CHARS_PER_ENTRY = 4;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic [1:0] {
        PHASE0 = 2'd0,
        PHASE1 = 2'd1,
        PHASE2 = 2'd2
    } phase_t;

    // One accepted byte worth of output characters
    typedef struct packed {
        logic [CHARS_PER_ENTRY-1:0][7:0] chars;
        logic [1:0]                      last_idx;
        logic                            fin;
    } entry_t;

    // Map a sextet onto the standard alphabet
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] ch;
        if (v < 6'd26) begin
            ch = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            ch = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            ch = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            ch = 8'h2B;
        end else begin
            ch = 8'h2F;
        end
        return ch;
    endfunction

endpackage

// ===== sv/base64_stream_encoder_top.sv =====
`timescale 1ns / 1ps

// Base64 stream encoder, standard alphabet with '=' padding.
// Input channel (s_): one raw byte per transfer, s_is_final on the message's
// last byte. Output channel (m_): one ASCII character per transfer, with
// m_run_end on the last character caused by an input byte and m_message_end
// on the last character of the message (after the padding, if any).
// The front stage tracks the position within each three-byte group and
// builds all characters for a byte at once; a short queue holds them; the back
// stage sends one per cycle while m_ready is high, via a registered output.
// The first character of a byte passes a queue slot and then the output
// register before it is presented.
// Throughput: one character per cycle while m_ready is high. A byte yields
// one or two characters while a message streams (four for every group of
// three bytes), up to four on the last byte. The single output register
// of the back stage sets this.
// Reset (aresetn low, synchronous) empties the queue, drops any pending
// output and restarts at the beginning of a group.
// When m_ready is low the output holds; the queue fills and s_ready falls
// once QUEUE_DEPTH bytes are waiting.

module base64_stream_encoder_top
    import b64e_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_is_final,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_run_end,
    output logic       m_message_end
);

    entry_t push_entry, head_entry;
    logic   push, push_ready, head_valid, pop;

    b64e_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_is_final  (s_is_final),
        .q_ready     (push_ready),
        .q_push      (push),
        .q_entry     (push_entry)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    b64e_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (head_valid),
        .q_entry       (head_entry),
        .q_pop         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_run_end     (m_run_end),
        .m_message_end (m_message_end)
    );

endmodule

// ===== sv/b64e_front.sv =====
`timescale 1ns / 1ps

module b64e_front
    import b64e_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_is_final,
    input  logic       q_ready,
    output logic       q_push,
    output entry_t     q_entry
);

    phase_t     phase_reg, phase_next;
    logic [3:0] left_reg, left_next;
    logic       accept;

    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;
    assign q_push  = accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE0;
            left_reg  <= 4'd0;
        end else begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

    // Next phase and leftover bits
    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        if (accept) begin
            if (s_is_final) begin
                phase_next = PHASE0;
                left_next  = 4'd0;
            end else begin
                unique case (phase_reg)
                    PHASE1: begin
                        phase_next = PHASE2;
                        left_next  = s_data_byte[3:0];
                    end
                    PHASE2: begin
                        phase_next = PHASE0;
                        left_next  = 4'd0;
                    end
                    default: begin
                        phase_next = PHASE1;
                        left_next  = {2'b00, s_data_byte[1:0]};
                    end
                endcase
            end
        end
    end

    // Characters that this byte completes, with flush and padding on the last byte
    always_comb begin
        q_entry.fin      = s_is_final;
        q_entry.chars[2] = PAD_CHAR;
        q_entry.chars[3] = PAD_CHAR;
        unique case (phase_reg)
            PHASE1: begin
                q_entry.chars[0] = sextet_char({left_reg[1:0], s_data_byte[7:4]});
                q_entry.chars[1] = sextet_char({s_data_byte[3:0], 2'b00});
                q_entry.last_idx = s_is_final ? 2'd2 : 2'd0;
            end
            PHASE2: begin
                q_entry.chars[0] = sextet_char({left_reg, s_data_byte[7:6]});
                q_entry.chars[1] = sextet_char(s_data_byte[5:0]);
                q_entry.last_idx = 2'd1;
            end
            default: begin
                q_entry.chars[0] = sextet_char(s_data_byte[7:2]);
                q_entry.chars[1] = sextet_char({s_data_byte[1:0], 4'b0000});
                q_entry.last_idx = s_is_final ? 2'd3 : 2'd0;
            end
        endcase
    end

    a_final_restarts_group: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_is_final) |=> (phase_reg == PHASE0 && left_reg == 4'd0))
        else $error("group not restarted after last byte");

endmodule

// ===== sv/b64e_queue.sv =====
`timescale 1ns / 1ps

module b64e_queue
    import b64e_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   push_ready,
    input  logic   pop,
    output logic   head_valid,
    output entry_t head_entry
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t           slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_entry = slots_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= CNT_FULL))
        else $error("queue count beyond depth");

endmodule

// ===== sv/b64e_back.sv =====
`timescale 1ns / 1ps

module b64e_back
    import b64e_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  entry_t     q_entry,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_run_end,
    output logic       m_message_end
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       run_end_reg, run_end_next;
    logic       msg_end_reg, msg_end_next;
    logic       load, at_last;

    // Output register frees up when empty or when its transfer completes
    assign load    = q_valid && (!valid_reg || m_ready);
    assign at_last = (idx_reg == q_entry.last_idx);
    assign q_pop   = load && at_last;

    always_comb begin
        idx_next     = idx_reg;
        valid_next   = valid_reg;
        char_next    = char_reg;
        run_end_next = run_end_reg;
        msg_end_next = msg_end_reg;
        if (load) begin
            valid_next   = 1'b1;
            char_next    = q_entry.chars[idx_reg];
            run_end_next = at_last;
            msg_end_next = at_last && q_entry.fin;
            idx_next     = at_last ? 2'd0 : idx_reg + 2'd1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg    <= char_next;
        run_end_reg <= run_end_next;
        msg_end_reg <= msg_end_next;
    end

    assign m_valid       = valid_reg;
    assign m_out_char    = char_reg;
    assign m_run_end     = run_end_reg;
    assign m_message_end = msg_end_reg;

    a_idx_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_valid |-> (idx_reg == 2'd0))
        else $error("character index left mid-run with no entry");

    a_idx_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> (idx_reg <= q_entry.last_idx))
        else $error("character index beyond end of run");

    a_msg_end_on_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (!m_message_end || m_run_end))
        else $error("message end without run end");

endmodule

// ===== verif/tb_base64_stream_encoder_top.sv =====
`timescale 1ns / 1ps

module tb_base64_stream_encoder_top;
    import b64e_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_BYTES = 420;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       message_end;
    } encoded_char_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_PATTERN,
        RX_RANDOM,
        RX_SPARSE
    } rx_mode_t;

    // Tracks the encoder's group position and queues the characters each byte yields
    class base64_char_tracker;
        string           alphabet_str =
            "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        phase_t          group_phase  = PHASE0;
        logic [3:0]      carry_bits   = '0;
        encoded_char_t   pending_chars[$];
        int unsigned     errors       = 0;

        function logic [7:0] symbol(logic [5:0] idx);
            return alphabet_str[int'(idx)];
        endfunction

        function void predict_chars(logic [7:0] b, logic fin);
            logic [7:0]    chars[$];
            encoded_char_t rec;
            int            last;
            case (group_phase)
                PHASE1: begin
                    chars.push_back(symbol({carry_bits[1:0], b[7:4]}));
                    if (fin) begin
                        chars.push_back(symbol({b[3:0], 2'b00}));
                        chars.push_back(PAD_CHAR);
                    end
                    group_phase = PHASE2;
                    carry_bits  = b[3:0];
                end
                PHASE2: begin
                    chars.push_back(symbol({carry_bits, b[7:6]}));
                    chars.push_back(symbol(b[5:0]));
                    group_phase = PHASE0;
                    carry_bits  = '0;
                end
                default: begin
                    chars.push_back(symbol(b[7:2]));
                    if (fin) begin
                        chars.push_back(symbol({b[1:0], 4'b0000}));
                        chars.push_back(PAD_CHAR);
                        chars.push_back(PAD_CHAR);
                    end
                    group_phase = PHASE1;
                    carry_bits  = {2'b00, b[1:0]};
                end
            endcase
            last = chars.size() - 1;
            foreach (chars[i]) begin
                rec.ch          = chars[i];
                rec.run_end     = (i == last);
                rec.message_end = fin && (i == last);
                pending_chars.push_back(rec);
            end
            // a finished message restarts at the head of a group
            if (fin) begin
                group_phase = PHASE0;
                carry_bits  = '0;
            end
        endfunction

        function void check_char(logic [7:0] ch, logic run_end, logic message_end);
            encoded_char_t exp_rec;
            if (pending_chars.size() == 0) begin
                errors++;
                $display("%0t: unexpected character: expected none, got %h run_end %b msg_end %b",
                         $time, ch, run_end, message_end);
                return;
            end
            exp_rec = pending_chars.pop_front();
            if (ch !== exp_rec.ch) begin
                errors++;
                $display("%0t: out_char mismatch: expected %h, got %h",
                         $time, exp_rec.ch, ch);
            end
            if (run_end !== exp_rec.run_end) begin
                errors++;
                $display("%0t: run_end mismatch: expected %b, got %b",
                         $time, exp_rec.run_end, run_end);
            end
            if (message_end !== exp_rec.message_end) begin
                errors++;
                $display("%0t: message_end mismatch: expected %b, got %b",
                         $time, exp_rec.message_end, message_end);
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte   = 8'h00;
    logic       s_is_final    = 1'b0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [7:0] m_out_char;
    logic       m_run_end;
    logic       m_message_end;

    base64_char_tracker tracker;
    int unsigned        burst_left   = 6;
    int unsigned        gap_len      = 3;
    logic               hold_request = 1'b0;

    base64_stream_encoder_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_is_final    (s_is_final),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_run_end     (m_run_end),
        .m_message_end (m_message_end)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Offer one byte, hold it until the transfer, then idle between bursts
    task automatic offer_byte(input logic [7:0] b, input logic fin);
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_is_final  <= fin;
        do @(posedge aclk); while (!s_ready);
        tracker.predict_chars(b, fin);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat (gap_len) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 10);
            gap_len    = $urandom_range(1, 10);
        end
    endtask

    task automatic wait_for_drain();
        if (s_valid) s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.pending_chars.size() != 0);
    endtask

    // Receiver: check each transfer, then pick the next ready level
    initial begin
        rx_mode_t    rx_mode;
        int unsigned mode_left;
        int unsigned hold_left;
        logic [15:0] stall_pattern;
        logic        next_ready;
        rx_mode       = RX_ALWAYS;
        mode_left     = 100;
        hold_left     = 0;
        stall_pattern = 16'b1011_0010_1110_0110;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                tracker.check_char(m_out_char, m_run_end, m_message_end);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(64, 300);
            end else begin
                mode_left--;
            end
            stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:  next_ready = 1'b1;
                    RX_PATTERN: next_ready = stall_pattern[0];
                    RX_RANDOM:  next_ready = ($urandom_range(0, 9) < 6);
                    default:    next_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
            m_ready <= next_ready;
        end
    end

    initial begin
        logic [7:0]  directed_bytes[25] = '{
            8'h00,
            8'hFF,
            8'h00, 8'hFF,
            8'hFF, 8'h00, 8'hFF,
            8'h4D, 8'h61, 8'h6E,
            8'hFB, 8'hEF, 8'hBE, 8'hFF,
            8'hF8, 8'h3E, 8'h0F, 8'hC0, 8'h7F,
            8'h01, 8'h02, 8'h80, 8'h40, 8'hAA, 8'h55
        };
        int unsigned directed_lens[8] = '{1, 1, 2, 3, 3, 4, 5, 6};
        int unsigned idx;
        int unsigned msg_len;
        int unsigned sent_bytes;
        logic        drained;
        logic        pressed;
        logic [7:0]  b;

        tracker = new;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every ending phase, pads, both alphabet ends and the '+' and '/' symbols
        idx = 0;
        foreach (directed_lens[m]) begin
            for (int i = 0; i < directed_lens[m]; i++) begin
                offer_byte(directed_bytes[idx], i == directed_lens[m] - 1);
                idx++;
            end
        end

        sent_bytes = 0;
        drained    = 1'b0;
        pressed    = 1'b0;
        while (sent_bytes < RANDOM_BYTES) begin
            msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 9);
            if (!drained && sent_bytes >= 150) begin
                wait_for_drain();
                drained = 1'b1;
            end
            // stall the receiver while a long message streams in back to back
            if (!pressed && sent_bytes >= 280) begin
                hold_request = 1'b1;
                burst_left   = 40;
                msg_len      = 24;
                pressed      = 1'b1;
            end
            for (int i = 0; i < msg_len; i++) begin
                if ($urandom_range(0, 7) == 0)
                    b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                else
                    b = 8'($urandom_range(0, 255));
                offer_byte(b, i == msg_len - 1);
                sent_bytes++;
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending_chars.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== base64_stream_encoder_top.f =====
sv/b64e_pkg.sv
sv/b64e_front.sv
sv/b64e_queue.sv
sv/b64e_back.sv
sv/base64_stream_encoder_top.sv
verif/tb_base64_stream_encoder_top.sv
